### rtl/bfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap frame allocator: frame and word
// geometry, command codes, payload structs and the word unit control struct.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int NUM_FRAMES = 65536;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int PTR_W      = $clog2(WORD_COUNT);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int HINT_W     = PTR_W + 1;

    localparam int CMD_W      = 2;
    localparam int FRAME_IN_W = 20;
    localparam int FRAME_W    = 16;
    localparam int COUNT_W    = 17;

    localparam logic [COUNT_W-1:0]   FRAME_TOTAL = COUNT_W'(NUM_FRAMES);
    localparam logic [HINT_W-1:0]    HINT_NONE   = HINT_W'(WORD_COUNT);
    localparam logic [PTR_W-1:0]     LAST_WORD   = PTR_W'(WORD_COUNT - 1);
    localparam logic [WORD_BITS-1:0] FULL_WORD   = '1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

    // Word unit operations
    localparam logic [1:0] WU_FILL  = 2'd0;
    localparam logic [1:0] WU_INIT  = 2'd1;
    localparam logic [1:0] WU_ALLOC = 2'd2;
    localparam logic [1:0] WU_FREE  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [FRAME_IN_W-1:0] frame;
    } t_bfa_in;

    typedef struct packed {
        logic [FRAME_W-1:0] alloc_frame;
        logic               alloc_failed;
        logic [COUNT_W-1:0] free_count;
    } t_bfa_out;

    typedef struct packed {
        logic [1:0]       op;
        logic [PTR_W-1:0] word_idx;
        logic [BIT_W-1:0] bit_idx;
        logic [COUNT_W-1:0] keep;
    } t_wu_ctrl;

    typedef struct packed {
        logic             full;
        logic [BIT_W-1:0] low_free;
    } t_wu_stat;

endpackage
`default_nettype wire

### rtl/bfa_bitmap_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_bitmap_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bfa_bitmap_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/bfa_word_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_word_unit
// Shared word unit: checks a bitmap word for a free bit, finds the lowest
// one, and builds the word to write back for fill, init, alloc and free.
// ----------------------------------------------------------------------------
module bfa_word_unit
    import bfa_pkg::*;
(
    input  wire t_wu_ctrl                   i_ctrl,
    input  wire logic     [WORD_BITS-1:0]   i_word,
    output t_wu_stat                        o_stat,
    output logic          [WORD_BITS-1:0]   o_word
);

    logic [WORD_BITS-1:0] zeros;
    logic [15:0]          z16;
    logic [7:0]           z8;
    logic [3:0]           z4;
    logic [1:0]           z2;
    logic [BIT_W-1:0]     low;
    logic [PTR_W:0]       keep_word;
    logic [BIT_W-1:0]     keep_bit;
    logic [WORD_BITS-1:0] init_word;

    // Lowest clear bit by halving search
    always_comb begin
        zeros  = ~i_word;
        low[4] = ~|zeros[15:0];
        z16    = low[4] ? zeros[31:16] : zeros[15:0];
        low[3] = ~|z16[7:0];
        z8     = low[3] ? z16[15:8] : z16[7:0];
        low[2] = ~|z8[3:0];
        z4     = low[2] ? z8[7:4] : z8[3:0];
        low[1] = ~|z4[1:0];
        z2     = low[1] ? z4[3:2] : z4[1:0];
        low[0] = ~z2[0];
    end

    // Init word: ones below the reserved boundary, zeros above
    always_comb begin
        keep_word = i_ctrl.keep[COUNT_W-1:BIT_W];
        keep_bit  = i_ctrl.keep[BIT_W-1:0];
        if ({1'b0, i_ctrl.word_idx} < keep_word) begin
            init_word = FULL_WORD;
        end else if ({1'b0, i_ctrl.word_idx} == keep_word) begin
            init_word = (WORD_BITS'(1) << keep_bit) - WORD_BITS'(1);
        end else begin
            init_word = '0;
        end
    end

    always_comb begin
        o_stat.full     = (i_word == FULL_WORD);
        o_stat.low_free = low;
        unique case (i_ctrl.op)
            WU_FILL:  o_word = FULL_WORD;
            WU_INIT:  o_word = init_word;
            WU_ALLOC: o_word = i_word | (WORD_BITS'(1) << low);
            WU_FREE:  o_word = i_word & ~(WORD_BITS'(1) << i_ctrl.bit_idx);
            default:  o_word = FULL_WORD;
        endcase
    end

endmodule
`default_nettype wire

### rtl/bitmap_frame_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_core
// First-fit physical frame allocator over a used/free bitmap held in a
// 2048 x 32 RAM, with a saturating count of free frames.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Transfer
//  --------  -------------------------------  ---------------------------------
//  command   start, i_item (cmd, frame)       start high and busy low at edge
//  result    o_strobe, o_result               o_strobe high, one cycle, no stall
//  config    i_cfg_we, i_cfg_wdata            i_cfg_we high at edge
//
//  Timing: cmd 3, out-of-range free and alloc with nothing free return their
//  result in the cycle after the transfer; free in range passes S_FWR, then the
//  strobe register. Alloc reads one bitmap word per cycle in S_ACHK from the first
//  word that may hold a free bit, then registers its result. Init sweeps all 2048
//  words, one write a cycle. Reset: a fill pass writes every word to all-used;
//  busy stays high until it ends. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_core
    import bfa_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire t_bfa_in             i_item,
    output logic                     o_strobe,
    output t_bfa_out                 o_result,
    input  wire logic                i_cfg_we,
    input  wire logic [COUNT_W-1:0]  i_cfg_wdata
);

    localparam logic [2:0] S_FILL = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_ACHK = 3'd3;
    localparam logic [2:0] S_FWR  = 3'd4;

    logic [2:0]         r_state,    n_state;
    logic [PTR_W-1:0]   r_ptr,      n_ptr;
    logic [BIT_W-1:0]   r_bit,      n_bit;
    logic [HINT_W-1:0]  r_hint,     n_hint;
    logic [COUNT_W-1:0] r_count,    n_count;
    logic [COUNT_W-1:0] r_keep,     n_keep;
    logic [COUNT_W-1:0] r_reserved;
    logic               r_strobe,   n_strobe;
    t_bfa_out           r_result,   n_result;

    logic                 ram_we;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] unit_word;
    t_wu_ctrl             unit_ctrl;
    t_wu_stat             unit_stat;
    logic                 accept;
    logic                 in_range;
    logic [PTR_W-1:0]     free_word;
    logic [COUNT_W-1:0]   keep_clamped;

    bfa_bitmap_ram #(
        .DEPTH (WORD_COUNT),
        .WIDTH (WORD_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr),
        .i_wdata (unit_word),
        .i_raddr (n_ptr),
        .o_rdata (ram_rdata)
    );

    bfa_word_unit u_unit (
        .i_ctrl (unit_ctrl),
        .i_word (ram_rdata),
        .o_stat (unit_stat),
        .o_word (unit_word)
    );

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign in_range  = (i_item.frame < FRAME_IN_W'(NUM_FRAMES));
    assign free_word = i_item.frame[BIT_W +: PTR_W];
    // Clamp the reserved count to the number of frames
    assign keep_clamped = (r_reserved > FRAME_TOTAL) ? FRAME_TOTAL : r_reserved;

    // Pick the word unit operation from the sequencer state
    always_comb begin
        unit_ctrl.word_idx = r_ptr;
        unit_ctrl.bit_idx  = r_bit;
        unit_ctrl.keep     = r_keep;
        unique case (r_state)
            S_INIT:  unit_ctrl.op = WU_INIT;
            S_ACHK:  unit_ctrl.op = WU_ALLOC;
            S_FWR:   unit_ctrl.op = WU_FREE;
            default: unit_ctrl.op = WU_FILL;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_bit    = r_bit;
        n_hint   = r_hint;
        n_count  = r_count;
        n_keep   = r_keep;
        n_strobe = 1'b0;
        n_result = r_result;
        ram_we   = 1'b0;

        unique case (r_state)
            S_FILL: begin
                // Write every word as all-used after reset
                ram_we = 1'b1;
                n_ptr  = r_ptr + PTR_W'(1);
                if (r_ptr == LAST_WORD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_result.alloc_frame  = '0;
                    n_result.alloc_failed = 1'b0;
                    n_result.free_count   = r_count;
                    case (i_item.cmd)
                        CMD_ALLOC: begin
                            if (r_hint == HINT_NONE) begin
                                // Nothing free: fail without a scan
                                n_result.alloc_failed = 1'b1;
                                n_strobe              = 1'b1;
                            end else begin
                                n_ptr   = r_hint[PTR_W-1:0];
                                n_state = S_ACHK;
                            end
                        end
                        CMD_FREE: begin
                            if (in_range) begin
                                n_ptr   = free_word;
                                n_bit   = i_item.frame[BIT_W-1:0];
                                n_state = S_FWR;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        CMD_INIT: begin
                            n_keep  = keep_clamped;
                            n_ptr   = '0;
                            n_state = S_INIT;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_INIT: begin
                // Sweep words, used below the boundary, free above it
                ram_we = 1'b1;
                n_ptr  = r_ptr + PTR_W'(1);
                if (r_ptr == LAST_WORD) begin
                    n_count             = FRAME_TOTAL - r_keep;
                    n_hint              = HINT_W'(r_keep[COUNT_W-1:BIT_W]);
                    n_result.free_count = FRAME_TOTAL - r_keep;
                    n_strobe            = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            S_ACHK: begin
                if (unit_stat.full) begin
                    // Skip a full word and read the next one
                    n_ptr = r_ptr + PTR_W'(1);
                    if (r_ptr == LAST_WORD) begin
                        n_hint                = HINT_NONE;
                        n_result.alloc_failed = 1'b1;
                        n_strobe              = 1'b1;
                        n_state               = S_IDLE;
                    end
                end else begin
                    ram_we = 1'b1;
                    if (r_count != '0) begin
                        n_count = r_count - COUNT_W'(1);
                    end
                    n_hint                = {1'b0, r_ptr};
                    n_result.alloc_frame  = {r_ptr, unit_stat.low_free};
                    n_result.free_count   = (r_count != '0) ? r_count - COUNT_W'(1) : r_count;
                    n_strobe              = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            S_FWR: begin
                // Clear the bit; the count saturates at the frame total
                ram_we = 1'b1;
                if (r_count < FRAME_TOTAL) begin
                    n_count = r_count + COUNT_W'(1);
                end
                if ({1'b0, r_ptr} < r_hint) begin
                    n_hint = {1'b0, r_ptr};
                end
                n_result.free_count = (r_count < FRAME_TOTAL) ? r_count + COUNT_W'(1)
                                                              : r_count;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_FILL;
            r_ptr      <= '0;
            r_hint     <= HINT_NONE;
            r_count    <= '0;
            r_reserved <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_hint   <= n_hint;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_reserved <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit    <= n_bit;
        r_keep   <= n_keep;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire

### sim/bitmap_frame_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_core_tb
// Self-checking bench for the first-fit frame allocator. A directed table
// walks the empty, full, clamped and saturated corners. Random phases follow,
// each one a reserved-count write and an init, then mostly alloc/free traffic.
// A bit-accurate bitmap predictor supplies the expected result of each
// transfer not fixed by the table; results are checked in order as they come out.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_core_tb
    import bfa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Command code that the block treats as a no-op status query
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    localparam int RANDOM_ITEMS = 400;

    typedef struct packed {
        logic               is_cfg;
        logic [COUNT_W-1:0] cfg_value;
        t_bfa_in            item;
        logic               known;
        t_bfa_out           want;
    } t_plan_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_bfa_in            i_item;
    logic               o_strobe;
    t_bfa_out           o_result;
    logic               i_cfg_we;
    logic [COUNT_W-1:0] i_cfg_wdata;

    // Shadow copy of the allocator state
    logic [WORD_BITS-1:0] used_map [WORD_COUNT];
    logic [COUNT_W-1:0]   free_cnt;
    logic [COUNT_W-1:0]   reserved_cfg;

    t_bfa_out    pending_results [$];
    logic [15:0] taken_frames [$];
    t_plan_row   plan [$];

    int unsigned fail_count;
    int unsigned results_seen;
    bit          no_gaps;

    bitmap_frame_allocator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Fail-safe: the slowest legal run needs under a fifth of this
    initial begin
        #60_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        $display("[%0t] result %0d %s: got %0h, expected %0h",
                 $time, results_seen, what, got, want);
    endtask

    // Apply one command to the shadow state and return the result it produces
    function automatic t_bfa_out step_allocator(input t_bfa_in it);
        t_bfa_out r;
        logic     hit;
        int       w;
        int       b;
        int       keep;
        int       lo;
        r   = '0;
        hit = 1'b0;
        case (it.cmd)
            CMD_ALLOC: begin
                // First fit: skip full words, take the lowest clear bit
                for (w = 0; w < WORD_COUNT && !hit; w++) begin
                    if (used_map[w] != FULL_WORD) begin
                        for (b = 0; b < WORD_BITS && !hit; b++) begin
                            if (!used_map[w][b]) begin
                                hit            = 1'b1;
                                used_map[w][b] = 1'b1;
                                r.alloc_frame  = FRAME_W'(w * WORD_BITS + b);
                            end
                        end
                    end
                end
                if (hit) begin
                    // Count floors at zero even when a clear bit was found
                    if (free_cnt != '0) free_cnt--;
                end else begin
                    r.alloc_failed = 1'b1;
                end
            end
            CMD_FREE: begin
                // Out-of-range frames are dropped; double frees still count
                if (it.frame < NUM_FRAMES) begin
                    used_map[it.frame / WORD_BITS][it.frame % WORD_BITS] = 1'b0;
                    if (free_cnt < FRAME_TOTAL) free_cnt++;
                end
            end
            CMD_INIT: begin
                // Clamp the reserved count to the frame total
                keep = (reserved_cfg > NUM_FRAMES) ? NUM_FRAMES : int'(reserved_cfg);
                for (w = 0; w < WORD_COUNT; w++) begin
                    lo = w * WORD_BITS;
                    if (keep >= lo + WORD_BITS) begin
                        used_map[w] = FULL_WORD;
                    end else if (keep <= lo) begin
                        used_map[w] = '0;
                    end else begin
                        used_map[w] = (32'h1 << (keep - lo)) - 32'h1;
                    end
                end
                free_cnt = COUNT_W'(NUM_FRAMES - keep);
            end
            default: begin
            end
        endcase
        r.free_count = free_cnt;
        return r;
    endfunction

    // Compare every strobed result against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_bfa_out want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result", o_result, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_result.alloc_frame !== want.alloc_frame)
                    flag_mismatch("alloc_frame", o_result.alloc_frame, want.alloc_frame);
                if (o_result.alloc_failed !== want.alloc_failed)
                    flag_mismatch("alloc_failed", o_result.alloc_failed, want.alloc_failed);
                if (o_result.free_count !== want.free_count)
                    flag_mismatch("free_count", o_result.free_count, want.free_count);
            end
        end
    end

    // Mostly back-to-back, sometimes a short pause, rarely a long one
    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one command, hold it until the transfer, then queue its result
    task automatic send_item(input t_bfa_in it, input logic known, input t_bfa_out want);
        t_bfa_out    predicted;
        int unsigned gap;
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predicted = step_allocator(it);
        pending_results.push_back(known ? want : predicted);
        if (it.cmd == CMD_INIT) begin
            taken_frames.delete();
        end else if (it.cmd == CMD_ALLOC && !predicted.alloc_failed) begin
            taken_frames.push_back(predicted.alloc_frame);
        end
        gap = idle_cycles();
        if (gap != 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drop start and wait until every result is back and the block is idle
    task automatic settle_block();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_reserved(input logic [COUNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we     <= 1'b1;
        i_cfg_wdata  <= value;
        reserved_cfg  = value;
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
    endtask

    task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [FRAME_IN_W-1:0] frame,
                           input logic known, input logic [FRAME_W-1:0] af,
                           input logic failed, input logic [COUNT_W-1:0] cnt);
        t_plan_row row;
        row = '0;
        row.item.cmd           = cmd;
        row.item.frame         = frame;
        row.known              = known;
        row.want.alloc_frame   = af;
        row.want.alloc_failed  = failed;
        row.want.free_count    = cnt;
        plan.push_back(row);
    endtask

    task automatic add_cfg(input logic [COUNT_W-1:0] value);
        t_plan_row row;
        row           = '0;
        row.is_cfg    = 1'b1;
        row.cfg_value = value;
        plan.push_back(row);
    endtask

    function automatic logic [COUNT_W-1:0] pick_reserved();
        case ($urandom_range(0, 3))
            0:       return COUNT_W'($urandom_range(0, 2000));
            1:       return COUNT_W'(NUM_FRAMES - $urandom_range(0, 40));
            2:       return COUNT_W'($urandom_range(0, NUM_FRAMES));
            default: return COUNT_W'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        t_bfa_in     it;
        int unsigned sent;
        int unsigned len;
        int unsigned idx;
        int unsigned r;

        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n     = 1'b0;
        fail_count  = 0;
        results_seen = 0;
        no_gaps     = 1'b0;
        foreach (used_map[w]) used_map[w] = FULL_WORD;
        free_cnt     = '0;
        reserved_cfg = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners; the reset fill pass is absorbed by the busy wait
        add_cmd(CMD_ALLOC, 20'h00000, 1'b1, 16'd0,    1'b1, 17'd0);      // nothing free
        add_cmd(CMD_NOP,   20'h5A5A5, 1'b1, 16'd0,    1'b0, 17'd0);
        add_cmd(CMD_FREE,  20'hFFFFF, 1'b1, 16'd0,    1'b0, 17'd0);      // out of range
        add_cmd(CMD_FREE,  20'h10000, 1'b1, 16'd0,    1'b0, 17'd0);      // first out of range
        add_cmd(CMD_FREE,  20'h00000, 1'b1, 16'd0,    1'b0, 17'd1);
        add_cmd(CMD_ALLOC, 20'hFFFFF, 1'b1, 16'd0,    1'b0, 17'd0);
        add_cmd(CMD_INIT,  20'hAAAAA, 1'b1, 16'd0,    1'b0, 17'h10000);  // all free
        add_cmd(CMD_FREE,  20'd100,   1'b1, 16'd0,    1'b0, 17'h10000);  // saturates
        add_cmd(CMD_ALLOC, 20'h00000, 1'b1, 16'd0,    1'b0, 17'hFFFF);
        add_cmd(CMD_ALLOC, 20'h00000, 1'b1, 16'd1,    1'b0, 17'hFFFE);
        add_cmd(CMD_FREE,  20'h00000, 1'b1, 16'd0,    1'b0, 17'hFFFF);
        add_cmd(CMD_ALLOC, 20'h55555, 1'b0, 16'd0,    1'b0, 17'd0);
        add_cfg(17'h10000);
        add_cmd(CMD_INIT,  20'h00000, 1'b1, 16'd0,    1'b0, 17'd0);      // everything reserved
        add_cmd(CMD_ALLOC, 20'h00000, 1'b1, 16'd0,    1'b1, 17'd0);
        add_cmd(CMD_FREE,  20'h0FFFF, 1'b1, 16'd0,    1'b0, 17'd1);      // top frame
        add_cmd(CMD_ALLOC, 20'h00000, 1'b1, 16'hFFFF, 1'b0, 17'd0);
        add_cfg(17'h1FFFF);
        add_cmd(CMD_INIT,  20'h00000, 1'b1, 16'd0,    1'b0, 17'd0);      // clamped
        add_cmd(CMD_ALLOC, 20'h00000, 1'b1, 16'd0,    1'b1, 17'd0);
        add_cfg(17'hFFFF);
        add_cmd(CMD_INIT,  20'h00000, 1'b1, 16'd0,    1'b0, 17'd1);      // one free frame
        add_cmd(CMD_FREE,  20'h0FFFF, 1'b1, 16'd0,    1'b0, 17'd2);      // already free
        add_cmd(CMD_ALLOC, 20'h00000, 1'b1, 16'hFFFF, 1'b0, 17'd1);
        add_cmd(CMD_ALLOC, 20'h00000, 1'b1, 16'd0,    1'b1, 17'd1);      // count above bitmap
        add_cfg(17'd33);
        add_cmd(CMD_INIT,  20'h00000, 1'b0, 16'd0,    1'b0, 17'd0);
        add_cmd(CMD_ALLOC, 20'h00000, 1'b0, 16'd0,    1'b0, 17'd0);
        add_cmd(CMD_FREE,  20'd32,    1'b0, 16'd0,    1'b0, 17'd0);      // reserved frame
        add_cmd(CMD_ALLOC, 20'h00000, 1'b0, 16'd0,    1'b0, 17'd0);
        add_cmd(CMD_NOP,   20'hFFFFF, 1'b0, 16'd0,    1'b0, 17'd0);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle_block();
                write_reserved(plan[i].cfg_value);
            end else begin
                send_item(plan[i].item, plan[i].known, plan[i].want);
            end
        end

        // Random phases: new reserved count, init, then mostly alloc/free traffic
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle_block();
            write_reserved(pick_reserved());
            no_gaps  = ($urandom_range(0, 3) == 0);
            it.cmd   = CMD_INIT;
            it.frame = FRAME_IN_W'($urandom);
            send_item(it, 1'b0, '0);
            sent++;
            len = $urandom_range(20, 40);
            repeat (len) begin
                r        = $urandom_range(0, 99);
                it.frame = FRAME_IN_W'($urandom);
                if (r < 45) begin
                    it.cmd = CMD_ALLOC;
                end else if (r < 75 && taken_frames.size() != 0) begin
                    // Release something this phase handed out
                    it.cmd   = CMD_FREE;
                    idx      = $urandom_range(0, taken_frames.size() - 1);
                    it.frame = {4'h0, taken_frames[idx]};
                    taken_frames.delete(idx);
                end else if (r < 83) begin
                    it.cmd   = CMD_FREE;
                    it.frame = FRAME_IN_W'($urandom_range(0, NUM_FRAMES - 1));
                end else if (r < 90) begin
                    it.cmd = CMD_FREE;
                end else if (r < 95) begin
                    it.cmd = CMD_NOP;
                end else begin
                    it.cmd = CMD_INIT;
                end
                send_item(it, 1'b0, '0);
                sent++;
            end
        end

        // Drain, then leave room for any stray strobe after the last result
        settle_block();
        repeat (2100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
